>>> src/nidq_pkg.sv
// Shared types and constants for the three-node Newton interpolation unit.
// No dependencies.
package nidq_pkg;

    // Default number of fraction bits of the fixed-point words
    localparam int FRACTION_BITS_DEF = 16;

    // Configuration register indexes
    localparam logic [2:0] REG_NODE_0  = 3'd0;
    localparam logic [2:0] REG_NODE_1  = 3'd1;
    localparam logic [2:0] REG_NODE_2  = 3'd2;
    localparam logic [2:0] REG_VALUE_0 = 3'd3;
    localparam logic [2:0] REG_VALUE_1 = 3'd4;
    localparam logic [2:0] REG_VALUE_2 = 3'd5;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_COINCIDENT = 2'd1;
    localparam logic [1:0] STATUS_SATURATED  = 2'd2;

    // Coefficient sequencer states
    typedef enum logic [1:0] {
        SEQ_LOAD,
        SEQ_RUN,
        SEQ_FINISH,
        SEQ_READY
    } t_seq_state;

endpackage

>>> src/newton_interpolation_three_node_unit.sv
// Quadratic Newton interpolation: coefficients by a shared bit-serial divider,
// per-query evaluation in a seven-stage pipeline. Uses nidq_pkg.
//
// Throughput: one query per cycle once the coefficients are ready and while the output is not stalled.
// After reset and after every configuration write, the divider runs three
// divisions of 33+FRACTION_BITS steps each, with a load and a finish state
// apiece, during which the input is stalled.
// Reset (synchronous, active low) loads the register defaults and empties
// the pipeline.
module newton_interpolation_three_node_unit #(
    parameter int FRACTION_BITS = nidq_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // query channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_query_point,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_interpolated_value,
    output logic [1:0]         o_status
);

    localparam int NUMW = 33 + FRACTION_BITS;   // numerator magnitude width
    localparam int CW   = $clog2(NUMW);
    localparam int PW   = 65;                   // 32 x 33 product
    localparam int TW   = PW - FRACTION_BITS;   // product after scaling
    localparam logic [CW-1:0] LAST_STEP = CW'(NUMW - 1);

    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [31:0] r_x0, r_x1, r_x2, r_y0, r_y1, r_y2;
    logic               cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x0 <= 32'sd0;
            r_x1 <= 32'sd65536;
            r_x2 <= 32'sd131072;
            r_y0 <= 32'sd0;
            r_y1 <= 32'sd0;
            r_y2 <= 32'sd0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                nidq_pkg::REG_NODE_0:  r_x0 <= i_cfg_data;
                nidq_pkg::REG_NODE_1:  r_x1 <= i_cfg_data;
                nidq_pkg::REG_NODE_2:  r_x2 <= i_cfg_data;
                nidq_pkg::REG_VALUE_0: r_y0 <= i_cfg_data;
                nidq_pkg::REG_VALUE_1: r_y1 <= i_cfg_data;
                nidq_pkg::REG_VALUE_2: r_y2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic coincident;
    assign coincident = (r_x0 == r_x1) || (r_x1 == r_x2) || (r_x0 == r_x2);

    // ---------------------------------------------------------------
    // Coefficient sequencer with bit-serial restoring divider
    // ---------------------------------------------------------------
    nidq_pkg::t_seq_state r_state, n_state;
    logic [1:0]           r_phase, n_phase;
    logic [CW-1:0]        r_cnt;
    logic [NUMW-1:0]      r_num, r_quo;
    logic [32:0]          r_rem, r_den;
    logic                 r_neg;
    logic signed [31:0]   r_f01, r_f12, r_a2;
    logic                 r_csat;

    // select operands for the current division
    logic signed [32:0] op_d, op_h;
    always_comb begin
        case (r_phase)
            2'd0: begin
                op_d = 33'(r_y1) - 33'(r_y0);
                op_h = 33'(r_x1) - 33'(r_x0);
            end
            2'd1: begin
                op_d = 33'(r_y2) - 33'(r_y1);
                op_h = 33'(r_x2) - 33'(r_x1);
            end
            default: begin
                op_d = 33'(r_f12) - 33'(r_f01);
                op_h = 33'(r_x2) - 33'(r_x0);
            end
        endcase
    end

    logic [32:0] d_mag, h_mag;
    assign d_mag = op_d[32] ? 33'(-op_d) : 33'(op_d);
    assign h_mag = op_h[32] ? 33'(-op_h) : 33'(op_h);

    // one restoring step
    logic [33:0] rem_sh;
    logic        q_bit;
    logic [32:0] rem_nx;
    assign rem_sh = {r_rem, r_num[NUMW-1]};
    assign q_bit  = rem_sh >= {1'b0, r_den};
    assign rem_nx = q_bit ? 33'(rem_sh - {1'b0, r_den}) : rem_sh[32:0];

    // apply sign and clamp the quotient
    logic [31:0] q_val;
    logic        q_sat;
    always_comb begin
        if (r_neg) begin
            q_sat = (|r_quo[NUMW-1:32]) || (r_quo[31] && (|r_quo[30:0]));
            q_val = q_sat ? Q_MIN : 32'(-r_quo[31:0]);
        end else begin
            q_sat = |r_quo[NUMW-1:31];
            q_val = q_sat ? Q_MAX : r_quo[31:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            nidq_pkg::SEQ_LOAD:   n_state = nidq_pkg::SEQ_RUN;
            nidq_pkg::SEQ_RUN:    if (r_cnt == LAST_STEP) n_state = nidq_pkg::SEQ_FINISH;
            nidq_pkg::SEQ_FINISH: begin
                if (r_phase == 2'd2) begin
                    n_state = nidq_pkg::SEQ_READY;
                end else begin
                    n_state = nidq_pkg::SEQ_LOAD;
                    n_phase = r_phase + 2'd1;
                end
            end
            default: n_state = nidq_pkg::SEQ_READY;
        endcase
        // restart on any configuration beat
        if (cfg_wr) begin
            n_state = nidq_pkg::SEQ_LOAD;
            n_phase = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nidq_pkg::SEQ_LOAD;
            r_phase <= 2'd0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // divider datapath and coefficient store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csat <= 1'b0;
        end else begin
            case (r_state)
                nidq_pkg::SEQ_LOAD: begin
                    r_num <= {d_mag, {FRACTION_BITS{1'b0}}};
                    r_den <= h_mag;
                    r_neg <= op_d[32] ^ op_h[32];
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= '0;
                    if (r_phase == 2'd0) r_csat <= 1'b0;
                end
                nidq_pkg::SEQ_RUN: begin
                    r_rem <= rem_nx;
                    r_num <= {r_num[NUMW-2:0], 1'b0};
                    r_quo <= {r_quo[NUMW-2:0], q_bit};
                    r_cnt <= r_cnt + 1'b1;
                end
                nidq_pkg::SEQ_FINISH: begin
                    case (r_phase)
                        2'd0:    r_f01 <= q_val;
                        2'd1:    r_f12 <= q_val;
                        default: r_a2  <= q_val;
                    endcase
                    r_csat <= r_csat | q_sat;
                end
                default: ;
            endcase
        end
    end

    logic coef_ready;
    assign coef_ready = (r_state == nidq_pkg::SEQ_READY);

    // ---------------------------------------------------------------
    // Evaluation pipeline
    // ---------------------------------------------------------------
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    logic en1, en2, en3, en4, en5, en6, en7;
    logic accept;

    // each stage advances when empty or when the next one advances
    assign en7 = !r7_v || !i_out_stall;
    assign en6 = !r6_v || en7;
    assign en5 = !r5_v || en6;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;

    assign o_in_stall = !(en1 && coef_ready);
    assign accept     = i_in_valid && !o_in_stall;

    logic signed [32:0] r1_dq1, r1_dq0, r2_dq0, r3_dq0, r4_dq0;
    logic signed [PW-1:0] r2_p, r5_p;
    logic signed [31:0] r3_t, r4_inner, r6_outer, r7_val;
    logic r3_sat, r4_sat, r5_sat, r6_sat;
    logic [1:0] r7_status;

    // scale a product toward zero and clamp it
    logic signed [TW-1:0] t3_raw, t6_raw;
    logic [TW-32:0]       t3_hi, t6_hi;
    logic                 t3_ok, t6_ok;
    assign t3_raw = TW'(r2_p >>> FRACTION_BITS)
                  + TW'(r2_p[PW-1] && (|r2_p[FRACTION_BITS-1:0]));
    assign t3_hi  = t3_raw[TW-1:31];
    assign t3_ok  = (&t3_hi) || !(|t3_hi);
    assign t6_raw = TW'(r5_p >>> FRACTION_BITS)
                  + TW'(r5_p[PW-1] && (|r5_p[FRACTION_BITS-1:0]));
    assign t6_hi  = t6_raw[TW-1:31];
    assign t6_ok  = (&t6_hi) || !(|t6_hi);

    // inner and final sums
    logic signed [32:0] s4, s7;
    logic               s4_ok, s7_ok;
    assign s4    = 33'(r_f01) + 33'(r3_t);
    assign s4_ok = s4[32] == s4[31];
    assign s7    = 33'(r_y0) + 33'(r6_outer);
    assign s7_ok = s7[32] == s7[31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0;
        end else begin
            if (en1) r1_v <= accept;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (en5) r5_v <= r4_v;
            if (en6) r6_v <= r5_v;
            if (en7) r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        // offsets from the nodes
        if (en1) begin
            r1_dq1 <= 33'(i_query_point) - 33'(r_x1);
            r1_dq0 <= 33'(i_query_point) - 33'(r_x0);
        end
        // a2 * (q - x1)
        if (en2) begin
            r2_p   <= PW'(r_a2) * PW'(r1_dq1);
            r2_dq0 <= r1_dq0;
        end
        // scale and clamp
        if (en3) begin
            r3_t   <= t3_ok ? t3_raw[31:0] : (t3_raw[TW-1] ? Q_MIN : Q_MAX);
            r3_sat <= !t3_ok;
            r3_dq0 <= r2_dq0;
        end
        // f01 + term, clamped
        if (en4) begin
            r4_inner <= s4_ok ? s4[31:0] : (s4[32] ? Q_MIN : Q_MAX);
            r4_sat   <= r3_sat || !s4_ok;
            r4_dq0   <= r3_dq0;
        end
        // inner * (q - x0)
        if (en5) begin
            r5_p   <= PW'(r4_inner) * PW'(r4_dq0);
            r5_sat <= r4_sat;
        end
        // scale and clamp
        if (en6) begin
            r6_outer <= t6_ok ? t6_raw[31:0] : (t6_raw[TW-1] ? Q_MIN : Q_MAX);
            r6_sat   <= r5_sat || !t6_ok;
        end
        // y0 + outer, clamped; resolve status
        if (en7) begin
            if (coincident) begin
                r7_val    <= 32'sd0;
                r7_status <= nidq_pkg::STATUS_COINCIDENT;
            end else begin
                r7_val    <= s7_ok ? s7[31:0] : (s7[32] ? Q_MIN : Q_MAX);
                r7_status <= (r6_sat || !s7_ok || r_csat) ? nidq_pkg::STATUS_SATURATED
                                                          : nidq_pkg::STATUS_OK;
            end
        end
    end

    assign o_out_valid          = r7_v;
    assign o_interpolated_value = r7_val;
    assign o_status             = r7_status;

endmodule
